FILE: rtl/assert_macros.svh
// assertion helpers shared by the decoder and the result buffer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define JSU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

   localparam int unsigned MaxResults = 4;

   // decoder position inside a string body
   typedef enum logic [3:0] {
      MODE_IDLE  = 4'd0,
      MODE_TEXT  = 4'd1,
      MODE_ESC   = 4'd2,
      MODE_HEX0  = 4'd3,
      MODE_HEX1  = 4'd4,
      MODE_HEX2  = 4'd5,
      MODE_HEX3  = 4'd6,
      MODE_BSL   = 4'd7,
      MODE_U     = 4'd8,
      MODE_LHEX0 = 4'd9,
      MODE_LHEX1 = 4'd10,
      MODE_LHEX2 = 4'd11,
      MODE_LHEX3 = 4'd12
   } mode_type;

   typedef enum logic [1:0] {
      ST_DATA = 2'd0,
      ST_END  = 2'd1,
      ST_ERR  = 2'd2
   } status_type;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LC_B  = 8'h62;
   localparam logic [7:0] CH_LC_F  = 8'h66;
   localparam logic [7:0] CH_LC_N  = 8'h6E;
   localparam logic [7:0] CH_LC_R  = 8'h72;
   localparam logic [7:0] CH_LC_T  = 8'h74;
   localparam logic [7:0] CH_LC_U  = 8'h75;

   // results caused by one input item
   typedef struct packed {
      logic [2:0]                        count;
      logic [MaxResults-1:0][7:0]        data;
      status_type [MaxResults-1:0]       status;
   } grp_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic [2:0]                 count;
      logic [MaxResults-1:0][7:0] data;
   } utf8_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r.ok    = 1'b1;
      r.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r.value = c[3:0] + 4'd9;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r.data = '0;
      if (cp < 21'h80) begin
         r.count   = 3'd1;
         r.data[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         r.count   = 3'd2;
         r.data[0] = {3'b110, cp[10:6]};
         r.data[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         r.count   = 3'd3;
         r.data[0] = {4'b1110, cp[15:12]};
         r.data[1] = {2'b10, cp[11:6]};
         r.data[2] = {2'b10, cp[5:0]};
      end else begin
         r.count   = 3'd4;
         r.data[0] = {5'b11110, cp[20:18]};
         r.data[1] = {2'b10, cp[17:12]};
         r.data[2] = {2'b10, cp[11:6]};
         r.data[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/jsu_decode.sv
`default_nettype none
`include "assert_macros.svh"

module jsu_decode
   import jsu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_valid,
   input  wire logic [7:0] item_ch,
   input  wire logic       item_first,
   input  wire logic       item_eot,
   input  wire logic       adv,
   output grp_type         grp
);

   mode_type    mode_ff, mode_in;
   logic [15:0] code_unit_ff, code_unit_in;
   logic [9:0]  high_half_ff, high_half_in;

   mode_type    mode;
   logic [15:0] cu;
   logic [9:0]  hh;
   logic [15:0] unit;
   logic        err;
   hex_type     hex;
   utf8_type    enc;

   always_comb begin
      mode = item_first ? MODE_TEXT : mode_ff;
      cu   = item_first ? 16'd0 : code_unit_ff;
      hh   = item_first ? 10'd0 : high_half_ff;
      hex  = hex_decode(item_ch);
      unit = {cu[11:0], hex.value};
      enc  = '0;
      err  = 1'b0;

      grp          = '0;
      mode_in      = mode;
      code_unit_in = cu;
      high_half_in = hh;

      if (!item_valid || mode == MODE_IDLE) begin
         // bytes outside a string are dropped
      end else if (item_eot) begin
         err = 1'b1;
      end else begin
         unique case (mode)
            MODE_TEXT: begin
               if (item_ch == CH_QUOTE) begin
                  grp.count     = 3'd1;
                  grp.status[0] = ST_END;
                  mode_in       = MODE_IDLE;
                  code_unit_in  = 16'd0;
                  high_half_in  = 10'd0;
               end else if (item_ch == CH_BSL) begin
                  mode_in = MODE_ESC;
               end else begin
                  grp.count   = 3'd1;
                  grp.data[0] = item_ch;
               end
            end
            MODE_ESC: begin
               grp.count = 3'd1;
               mode_in   = MODE_TEXT;
               unique case (item_ch)
                  CH_QUOTE: grp.data[0] = CH_QUOTE;
                  CH_BSL:   grp.data[0] = CH_BSL;
                  CH_SLASH: grp.data[0] = CH_SLASH;
                  CH_LC_N:  grp.data[0] = 8'h0A;
                  CH_LC_R:  grp.data[0] = 8'h0D;
                  CH_LC_T:  grp.data[0] = 8'h09;
                  CH_LC_B:  grp.data[0] = 8'h08;
                  CH_LC_F:  grp.data[0] = 8'h0C;
                  CH_LC_U: begin
                     grp.count    = 3'd0;
                     code_unit_in = 16'd0;
                     mode_in      = MODE_HEX0;
                  end
                  default: err = 1'b1;
               endcase
            end
            MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_LHEX0, MODE_LHEX1, MODE_LHEX2: begin
               if (!hex.ok) begin
                  err = 1'b1;
               end else begin
                  code_unit_in = unit;
                  mode_in      = mode_type'(mode + 4'd1);
               end
            end
            MODE_HEX3: begin
               if (!hex.ok) begin
                  err = 1'b1;
               end else if (unit[15:10] == 6'b110110) begin
                  // high surrogate, wait for the low half
                  high_half_in = unit[9:0];
                  code_unit_in = 16'd0;
                  mode_in      = MODE_BSL;
               end else begin
                  enc          = utf8_encode({5'd0, unit});
                  grp.count    = enc.count;
                  grp.data     = enc.data;
                  code_unit_in = 16'd0;
                  mode_in      = MODE_TEXT;
               end
            end
            MODE_BSL: begin
               if (item_ch == CH_BSL) mode_in = MODE_U;
               else err = 1'b1;
            end
            MODE_U: begin
               if (item_ch == CH_LC_U) begin
                  code_unit_in = 16'd0;
                  mode_in      = MODE_LHEX0;
               end else begin
                  err = 1'b1;
               end
            end
            MODE_LHEX3: begin
               if (!hex.ok || unit[15:10] != 6'b110111) begin
                  err = 1'b1;
               end else begin
                  enc          = utf8_encode(21'h10000 + {1'b0, hh, unit[9:0]});
                  grp.count    = enc.count;
                  grp.data     = enc.data;
                  code_unit_in = 16'd0;
                  high_half_in = 10'd0;
                  mode_in      = MODE_TEXT;
               end
            end
            default: err = 1'b1;
         endcase
      end

      if (err) begin
         grp           = '0;
         grp.count     = 3'd1;
         grp.status[0] = ST_ERR;
         mode_in       = MODE_IDLE;
         code_unit_in  = 16'd0;
         high_half_in  = 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         code_unit_ff <= 16'd0;
         high_half_ff <= 10'd0;
      end else if (adv) begin
         mode_ff      <= mode_in;
         code_unit_ff <= code_unit_in;
         high_half_ff <= high_half_in;
      end
   end

   `JSU_ASSERT_NEXT(a_err_goes_idle, adv && grp.count != 3'd0 && grp.status[0] == ST_ERR, mode_ff == MODE_IDLE, "decoder not idle after malformed string")
   `JSU_ASSERT(a_end_alone, (item_valid && grp.status[0] != ST_DATA) |-> grp.count == 3'd1, "end or error result not alone")

endmodule

`default_nettype wire

FILE: rtl/jsu_rsp_buf.sv
`default_nettype none
`include "assert_macros.svh"

module jsu_rsp_buf
   import jsu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire grp_type    grp,
   output logic            free,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic [1:0]      rsp_status,
   output logic            rsp_last
);

   logic [2:0]                  cnt_ff, cnt_in;
   logic [MaxResults-1:0][7:0]  data_ff, data_in;
   status_type [MaxResults-1:0] status_ff, status_in;
   logic                        take;

   assign rsp_valid    = cnt_ff != 3'd0;
   assign take         = rsp_valid && rsp_ready;
   assign free         = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_ready);
   assign rsp_out_byte = data_ff[0];
   assign rsp_status   = status_ff[0];
   assign rsp_last     = cnt_ff == 3'd1;

   always_comb begin
      cnt_in    = cnt_ff;
      data_in   = data_ff;
      status_in = status_ff;
      if (load) begin
         cnt_in    = grp.count;
         data_in   = grp.data;
         status_in = grp.status;
      end else if (take) begin
         // shift the next byte to the head
         cnt_in  = cnt_ff - 3'd1;
         data_in = {8'd0, data_ff[MaxResults-1:1]};
         for (int i = 0; i < int'(MaxResults) - 1; i++) status_in[i] = status_ff[i+1];
         status_in[MaxResults-1] = ST_DATA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      data_ff   <= data_in;
      status_ff <= status_in;
   end

   `JSU_ASSERT(a_cnt_range, cnt_ff <= 3'd4, "result count out of range")
   `JSU_ASSERT(a_load_free, load |-> (cnt_ff == 3'd0 || (cnt_ff == 3'd1 && rsp_ready)), "results overwritten before transfer")

endmodule

`default_nettype wire

FILE: rtl/json_string_unescape_utf8.sv
// JSON string body decoder: takes the raw bytes of a string body one per transfer, starting
// after the opening quote (req_first_byte high on the first one), and returns the decoded text
// as UTF-8 bytes with status 0, one byte per rsp transfer. A closing quote gives one status 1
// result; a bad escape, bad hex digit, unpaired high surrogate or req_end_of_text inside the
// string gives one status 2 result, after which bytes are dropped until the next
// req_first_byte. rsp_last marks the final result of each input item. Throughput is one input
// byte per cycle, while rsp_ready stays high, for bytes that give at most one result; a \u
// escape that expands to n UTF-8 bytes holds the result register until all n have been taken,
// since the result register hands out one byte a cycle. A request passes through the input
// register and then the result register before its first result appears.
`default_nettype none

module json_string_unescape_utf8
   import jsu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_ch,
   input  wire logic       req_first_byte,
   input  wire logic       req_end_of_text,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic [1:0]      rsp_status,
   output logic            rsp_last
);

   // input register, parts the request side from the result side
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic       in_first_ff;
   logic       in_eot_ff;

   grp_type    grp;
   logic       buf_free;
   logic       adv;
   logic       req_xfer;

   // the held item moves on when its results fit, or when it gives none
   assign adv       = in_valid_ff && (grp.count == 3'd0 || buf_free);
   assign req_ready = !in_valid_ff || adv;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) in_valid_in = 1'b1;
      else if (adv) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_xfer) begin
         in_ch_ff    <= req_ch;
         in_first_ff <= req_first_byte;
         in_eot_ff   <= req_end_of_text;
      end
   end

   // escape state machine and UTF-8 encoding
   jsu_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item_ch    (in_ch_ff),
      .item_first (in_first_ff),
      .item_eot   (in_eot_ff),
      .adv        (adv),
      .grp        (grp)
   );

   // result register, up to four bytes drained one per transfer
   jsu_rsp_buf u_rsp_buf (
      .clock        (clock),
      .reset        (reset),
      .load         (adv && grp.count != 3'd0),
      .grp          (grp),
      .free         (buf_free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
   import jsu_pkg::*;

   // one result transfer as the decoder should present it
   typedef struct {
      logic [7:0] data;
      status_type status;
      logic       last;
   } result_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_ch;
   logic       req_first_byte;
   logic       req_end_of_text;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_status;
   logic       rsp_last;

   // decoder state as the testbench sees it
   mode_type    dec_mode = MODE_IDLE;
   logic [15:0] unit_acc = '0;
   logic [9:0]  high_bits = '0;

   result_type decoded_q[$];     // results still owed by the block, oldest first
   result_type step_results[$];  // results caused by the byte being decoded
   int      err_count = 0;
   int      bytes_sent = 0;   // transfers that the decoder did not just drop
   int      stall_left = 0;
   bit      quiet = 1'b0;     // no gaps on either side while set
   bit      opening = 1'b0;   // next transfer carries req_first_byte

   json_string_unescape_utf8 u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_first_byte  (req_first_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #3_000_000;
      $display("tb: errors");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   function automatic int hex_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
   endfunction

   function automatic bit is_escape(input logic [7:0] c);
      case (c)
         CH_QUOTE, CH_BSL, CH_SLASH, CH_LC_B, CH_LC_F,
         CH_LC_N, CH_LC_R, CH_LC_T, CH_LC_U: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   task automatic note(input logic [7:0] b, input status_type st);
      result_type r;
      r.data   = b;
      r.status = st;
      r.last   = 1'b0;
      step_results = {step_results, r};
   endtask

   // code point to one to four utf-8 bytes
   task automatic note_utf8(input logic [20:0] cp);
      if (cp < 21'h80) begin
         note(cp[7:0], ST_DATA);
      end else if (cp < 21'h800) begin
         note(8'hC0 | {3'b000, cp[10:6]}, ST_DATA);
         note(8'h80 | {2'b00, cp[5:0]}, ST_DATA);
      end else if (cp < 21'h10000) begin
         note(8'hE0 | {4'b0000, cp[15:12]}, ST_DATA);
         note(8'h80 | {2'b00, cp[11:6]}, ST_DATA);
         note(8'h80 | {2'b00, cp[5:0]}, ST_DATA);
      end else begin
         note(8'hF0 | {5'b00000, cp[20:18]}, ST_DATA);
         note(8'h80 | {2'b00, cp[17:12]}, ST_DATA);
         note(8'h80 | {2'b00, cp[11:6]}, ST_DATA);
         note(8'h80 | {2'b00, cp[5:0]}, ST_DATA);
      end
   endtask

   task automatic malformed();
      note(8'h00, ST_ERR);
      dec_mode  = MODE_IDLE;
      unit_acc  = '0;
      high_bits = '0;
   endtask

   // advance the decoder by one accepted byte and queue what it owes
   task automatic decode_byte(input logic [7:0] c, input logic f, input logic e);
      int         h;
      result_type r;
      step_results.delete();
      if (f) begin
         dec_mode  = MODE_TEXT;
         unit_acc  = '0;
         high_bits = '0;
      end
      if (dec_mode == MODE_IDLE) return;
      if (e) begin
         malformed();
      end else begin
         case (dec_mode)
            MODE_TEXT: begin
               if (c == CH_QUOTE) begin
                  note(8'h00, ST_END);
                  dec_mode  = MODE_IDLE;
                  unit_acc  = '0;
                  high_bits = '0;
               end else if (c == CH_BSL) begin
                  dec_mode = MODE_ESC;
               end else begin
                  note(c, ST_DATA);
               end
            end
            MODE_ESC: begin
               dec_mode = MODE_TEXT;
               case (c)
                  CH_QUOTE, CH_BSL, CH_SLASH: note(c, ST_DATA);
                  CH_LC_N: note(8'h0A, ST_DATA);
                  CH_LC_R: note(8'h0D, ST_DATA);
                  CH_LC_T: note(8'h09, ST_DATA);
                  CH_LC_B: note(8'h08, ST_DATA);
                  CH_LC_F: note(8'h0C, ST_DATA);
                  CH_LC_U: begin
                     unit_acc = '0;
                     dec_mode = MODE_HEX0;
                  end
                  default: malformed();
               endcase
            end
            MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
               h = hex_value(c);
               if (h < 0) begin
                  malformed();
               end else begin
                  unit_acc = {unit_acc[11:0], h[3:0]};
                  if (dec_mode != MODE_HEX3) begin
                     dec_mode = mode_type'(dec_mode + 4'd1);
                  end else if (unit_acc >= 16'hD800 && unit_acc <= 16'hDBFF) begin
                     // high half of a pair: the low ten bits are its offset from 0xD800
                     high_bits = unit_acc[9:0];
                     unit_acc  = '0;
                     dec_mode  = MODE_BSL;
                  end else begin
                     // a lone low surrogate lands here too and is encoded as it stands
                     note_utf8({5'b00000, unit_acc});
                     unit_acc = '0;
                     dec_mode = MODE_TEXT;
                  end
               end
            end
            MODE_BSL: begin
               if (c == CH_BSL) dec_mode = MODE_U;
               else malformed();
            end
            MODE_U: begin
               if (c == CH_LC_U) begin
                  unit_acc = '0;
                  dec_mode = MODE_LHEX0;
               end else begin
                  malformed();
               end
            end
            MODE_LHEX0, MODE_LHEX1, MODE_LHEX2, MODE_LHEX3: begin
               h = hex_value(c);
               if (h < 0) begin
                  malformed();
               end else begin
                  unit_acc = {unit_acc[11:0], h[3:0]};
                  if (dec_mode != MODE_LHEX3) begin
                     dec_mode = mode_type'(dec_mode + 4'd1);
                  end else if (unit_acc < 16'hDC00 || unit_acc > 16'hDFFF) begin
                     malformed();
                  end else begin
                     note_utf8(21'h10000 + {1'b0, high_bits, unit_acc[9:0]});
                     unit_acc  = '0;
                     high_bits = '0;
                     dec_mode  = MODE_TEXT;
                  end
               end
            end
            default: malformed();
         endcase
      end
      for (int i = 0; i < step_results.size(); i++) begin
         r      = step_results[i];
         r.last = (i == step_results.size() - 1);
         decoded_q = {decoded_q, r};
      end
   endtask

   // ---------------------------------------------------------------- result side

   // rsp_ready: mostly high, short stalls now and then, the odd long one
   always @(posedge clock) begin : rsp_pacing
      int r;
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         r = $urandom_range(99);
         if (r < 70) begin
            rsp_ready <= 1'b1;
         end else if (r < 95) begin
            rsp_ready  <= 1'b0;
            stall_left = $urandom_range(2);
         end else begin
            rsp_ready  <= 1'b0;
            stall_left = $urandom_range(25, 8);
         end
      end
   end

   // every result transfer is matched against the oldest owed result
   always @(posedge clock) begin : check_rsp
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            $display("%0t: unexpected result, got byte %h status %0d last %b",
                     $time, rsp_out_byte, rsp_status, rsp_last);
            err_count++;
         end else begin
            want = decoded_q.pop_front();
            if (rsp_out_byte !== want.data || rsp_status !== want.status ||
                rsp_last !== want.last) begin
               $display("%0t: expected byte %h status %0d last %b, got byte %h status %0d last %b",
                        $time, want.data, want.status, want.last,
                        rsp_out_byte, rsp_status, rsp_last);
               err_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- request side

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(8, 4);
      return $urandom_range(30, 10);
   endfunction

   // one request transfer; valid stays up afterwards so back-to-back bytes need no gap
   task automatic send_byte(input logic [7:0] c, input logic f, input logic e);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_ch          <= c;
      req_first_byte  <= f;
      req_end_of_text <= e;
      do @(posedge clock); while (!req_ready);
      if (f || dec_mode != MODE_IDLE) bytes_sent++;
      decode_byte(c, f, e);
   endtask

   task automatic put(input logic [7:0] c);
      logic f;
      f       = opening;
      opening = 1'b0;
      send_byte(c, f, 1'b0);
   endtask

   task automatic put_eot();
      logic f;
      f       = opening;
      opening = 1'b0;
      send_byte(8'($urandom_range(255)), f, 1'b1);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put(s[i]);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 4'd10) return 8'h30 + n;
      return (upper ? 8'h41 : 8'h61) + n - 8'd10;
   endfunction

   // four hex digits, each in a random case
   task automatic put_unit(input logic [15:0] u);
      for (int i = 3; i >= 0; i--) put(hex_char(u[i*4 +: 4], 1'($urandom_range(1))));
   endtask

   task automatic put_escape_u();
      put(CH_BSL);
      put(CH_LC_U);
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c == CH_QUOTE || c == CH_BSL);
      return c;
   endfunction

   function automatic logic [7:0] simple_escape();
      case ($urandom_range(7))
         0: return CH_QUOTE;
         1: return CH_BSL;
         2: return CH_SLASH;
         3: return CH_LC_B;
         4: return CH_LC_F;
         5: return CH_LC_N;
         6: return CH_LC_R;
         default: return CH_LC_T;
      endcase
   endfunction

   // a code unit outside the surrogate range, spread over the utf-8 lengths
   function automatic logic [15:0] bmp_unit();
      case ($urandom_range(4))
         0: return 16'($urandom_range(16'h007F));
         1: return 16'($urandom_range(16'h07FF, 16'h0080));
         2: return 16'($urandom_range(16'hD7FF, 16'h0800));
         3: return 16'($urandom_range(16'hFFFF, 16'hE000));
         default: begin
            case ($urandom_range(5))
               0: return 16'h0000;
               1: return 16'h007F;
               2: return 16'h0080;
               3: return 16'h07FF;
               4: return 16'h0800;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [15:0] high_unit();
      return 16'hD800 | 16'($urandom_range(1023));
   endfunction

   // one well-formed piece of string body
   task automatic random_element();
      int k;
      k = $urandom_range(99);
      if (k < 45) begin
         put(plain_byte());
      end else if (k < 65) begin
         put(CH_BSL);
         put(simple_escape());
      end else if (k < 85) begin
         put_escape_u();
         put_unit(bmp_unit());
      end else if (k < 90) begin
         put_escape_u();
         put_unit(16'hDC00 | 16'($urandom_range(1023)));
      end else begin
         put_escape_u();
         put_unit(high_unit());
         put_escape_u();
         put_unit(16'hDC00 | 16'($urandom_range(1023)));
      end
   endtask

   // a string of random body, closed normally most of the time, broken otherwise
   task automatic random_string();
      int         k;
      logic [7:0] c;
      logic [15:0] u;
      opening = 1'b1;
      repeat ($urandom_range(6)) random_element();
      k = $urandom_range(99);
      if (k < 62) begin
         put(CH_QUOTE);
      end else if (k < 70) begin
         // text ends, sometimes half way through an escape
         if ($urandom_range(1)) begin
            put_escape_u();
            repeat ($urandom_range(3)) put(hex_char(4'($urandom_range(15)), 1'b0));
         end
         put_eot();
      end else if (k < 76) begin
         do c = 8'($urandom_range(255)); while (is_escape(c));
         put(CH_BSL);
         put(c);
      end else if (k < 82) begin
         do c = 8'($urandom_range(255)); while (hex_value(c) >= 0);
         put_escape_u();
         repeat ($urandom_range(3)) put(hex_char(4'($urandom_range(15)), 1'b1));
         put(c);
      end else if (k < 87) begin
         // high half not followed by a backslash
         do c = 8'($urandom_range(255)); while (c == CH_BSL);
         put_escape_u();
         put_unit(high_unit());
         put(c);
      end else if (k < 91) begin
         // backslash after the high half but no u
         do c = 8'($urandom_range(255)); while (c == CH_LC_U);
         put_escape_u();
         put_unit(high_unit());
         put(CH_BSL);
         put(c);
      end else if (k < 95) begin
         // second unit not a low half
         do u = 16'($urandom_range(16'hFFFF)); while (u >= 16'hDC00 && u <= 16'hDFFF);
         put_escape_u();
         put_unit(high_unit());
         put_escape_u();
         put_unit(u);
      end else begin
         // a fresh string opens in the middle of an escape
         put(CH_BSL);
         opening = 1'b1;
         random_element();
         put(CH_QUOTE);
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_outside_string();
      send_byte(8'h41, 1'b0, 1'b0);   // idle byte, dropped
      send_byte(8'hFF, 1'b0, 1'b1);   // text end while idle, nothing owed
      send_byte(8'h00, 1'b1, 1'b1);   // opens and ends at once: malformed
   endtask

   task automatic test_plain_bytes();
      opening = 1'b1;
      put(8'hFF);
      put(8'h00);                     // control byte passes through
      put(CH_QUOTE);
   endtask

   task automatic test_bad_escape();
      opening = 1'b1;
      put_text("\\x");
      put(8'h41);                     // dropped after the error
   endtask

   task automatic test_unicode();
      opening = 1'b1;
      put_text("\\uDbFf\\udFFf");     // highest pair, four bytes
      put_text("\\uDC00");            // lone low half, three bytes
      put_eot();                      // text ends inside the string
      opening = 1'b1;
      put_text("\\ud800a");           // high half left unpaired
      opening = 1'b1;
      put_text("\\ug");               // bad hex digit
   endtask

   task automatic test_random_strings();
      int start;
      int k;
      start = bytes_sent;
      while (bytes_sent - start < 150) begin
         quiet = ($urandom_range(3) == 0);
         k = $urandom_range(99);
         if (k < 6) begin
            repeat ($urandom_range(3, 1))
               send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
         end else if (k < 10) begin
            send_byte(8'($urandom_range(255)), 1'b1, 1'b1);
         end else begin
            random_string();
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_ch          <= 8'h00;
      req_first_byte  <= 1'b0;
      req_end_of_text <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_outside_string();
      test_plain_bytes();
      test_bad_escape();
      test_unicode();
      test_random_strings();

      // last transfer just went; drop valid and let the block drain
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (err_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
